// ===== src/csip_pkg.sv =====
`timescale 1ns / 1ps

package csip_pkg;

    localparam int IDX_W             = 27;
    localparam int COORD_W           = 9;
    localparam int DEFAULT_MAX_SHELL = 255;

    // Bounds that follow from the index width: the shell of any index stays below 258
    localparam int N_W    = 10;
    localparam int SQ_W   = 20;
    localparam int OFS_W  = 21;
    localparam int CUBE_W = 28;
    localparam int Q_W    = 10;

    typedef struct packed {
        logic                 beyond;
        logic [COORD_W-1:0]   r;
        logic [N_W-1:0]       n;
        logic [SQ_W-1:0]      nsq;
        logic [OFS_W-1:0]     ofs;
    } csip_shell_t;

endpackage

// ===== src/csip_in_if.sv =====
`timescale 1ns / 1ps

interface csip_in_if;
    import csip_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] position_index;

    modport source (output valid, output position_index, input ready);
    modport sink (input valid, input position_index, output ready);
endinterface

// ===== src/csip_out_if.sv =====
`timescale 1ns / 1ps

interface csip_out_if;
    import csip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      beyond_range;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output beyond_range, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input beyond_range, output ready);
endinterface

// ===== src/cube_shell_index_to_position_top.sv =====
`timescale 1ns / 1ps

// Cube shell index to position lookup.
// query channel (sink): position_index, one item per lookup.
// result channel (source): pos_x, pos_y, pos_z and beyond_range, one item per query.
// An index past shell MAX_SHELL returns beyond_range with zero coordinates.
// The shell search steps one radius per cycle, from shell 1 up to the index's
// shell (or up to MAX_SHELL for an index beyond range). Decoding then runs
// face/edge group compares for edge and corner points, or face group compares
// and a restoring division for face points, on one shared subtractor, then
// hands off through S_WRITE. Index zero skips the search and the decoding.
// One item is in flight at a time: query.ready is high only while idle.
// A finished item moves to the output register; the next query is taken while
// it waits. If the receiver stalls and that register is still full, the next
// result holds until it drains.
// Reset clears the sequencer and the output valid; no memory to clear.
module cube_shell_index_to_position_top #(
    parameter int MAX_SHELL = csip_pkg::DEFAULT_MAX_SHELL
) (
    input  logic         clk,
    input  logic         rst_n,
    csip_in_if.sink      query,
    csip_out_if.source   result
);
    import csip_pkg::*;

    localparam int BIT_W = $clog2(Q_W);
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(Q_W - 1);

    localparam logic [1:0] GRP_FIRST  = 2'd0;
    localparam logic [1:0] GRP_SECOND = 2'd1;
    localparam logic [1:0] GRP_THIRD  = 2'd2;
    localparam logic [1:0] GRP_DONE   = 2'd3;

    typedef enum logic [2:0] {S_IDLE, S_FIND, S_FACE, S_EDGE, S_DIV, S_WRITE} state_t;

    state_t                     state_reg;
    logic [OFS_W-1:0]           ofs_reg;
    logic [1:0]                 cnt_reg;
    logic [BIT_W-1:0]           bit_reg;
    logic [Q_W-1:0]             q_reg;
    logic                       sgn_reg;
    logic [COORD_W-1:0]         r_reg;
    logic [N_W-1:0]             n_reg;
    logic [SQ_W-1:0]            nsq_reg;
    logic [COORD_W-1:0]         x_reg;
    logic [COORD_W-1:0]         y_reg;
    logic [COORD_W-1:0]         z_reg;
    logic                       beyond_reg;
    logic                       out_valid_reg;
    logic signed [COORD_W-1:0]  out_x_reg;
    logic signed [COORD_W-1:0]  out_y_reg;
    logic signed [COORD_W-1:0]  out_z_reg;
    logic                       out_beyond_reg;

    logic                       accept;
    logic                       shell_start;
    logic                       shell_done;
    csip_shell_t                shell;

    logic [OFS_W-1:0]           sub_b;
    logic [OFS_W:0]             diff;
    logic                       ge;
    logic [Q_W-1:0]             q_new;
    logic [OFS_W-1:0]           rem_new;
    logic [COORD_W-1:0]         lo;
    logic [COORD_W-1:0]         s_pos;
    logic [COORD_W-1:0]         s_neg;
    logic [COORD_W-1:0]         face_s;
    logic [COORD_W-1:0]         face_va;
    logic [COORD_W-1:0]         face_vb;
    logic [COORD_W-1:0]         edge_va;
    logic [COORD_W-1:0]         edge_s1;
    logic [COORD_W-1:0]         edge_s2;
    logic [COORD_W-1:0]         corner_x;
    logic [COORD_W-1:0]         corner_y;
    logic [COORD_W-1:0]         corner_z;

    assign accept      = query.valid && query.ready;
    assign query.ready = (state_reg == S_IDLE);
    assign shell_start = accept && (query.position_index != '0);

    csip_shell_find #(
        .MAX_SHELL (MAX_SHELL)
    ) u_shell_find (
        .clk   (clk),
        .rst_n (rst_n),
        .start (shell_start),
        .idx   (query.position_index),
        .done  (shell_done),
        .shell (shell)
    );

    // shared subtract-and-compare unit
    always_comb
    begin
        case (state_reg)
            S_FACE:  sub_b = {nsq_reg, 1'b0};
            S_EDGE:  sub_b = OFS_W'({n_reg, 2'b00});
            S_DIV:   sub_b = OFS_W'(n_reg) << bit_reg;
            default: sub_b = '0;
        endcase
    end

    assign diff    = {1'b0, ofs_reg} - {1'b0, sub_b};
    assign ge      = ~diff[OFS_W];
    assign q_new   = q_reg | (Q_W'(ge) << bit_reg);
    assign rem_new = ge ? diff[OFS_W-1:0] : ofs_reg;

    assign lo       = r_reg - COORD_W'(1);
    assign s_pos    = r_reg;
    assign s_neg    = COORD_W'(0) - r_reg;
    assign face_s   = sgn_reg ? s_neg : s_pos;
    assign face_va  = q_new[COORD_W-1:0] - lo;
    assign face_vb  = rem_new[COORD_W-1:0] - lo;
    assign edge_va  = ofs_reg[COORD_W+1:2] - lo;
    assign edge_s1  = ofs_reg[1] ? s_neg : s_pos;
    assign edge_s2  = ofs_reg[0] ? s_neg : s_pos;
    assign corner_x = ofs_reg[2] ? s_neg : s_pos;
    assign corner_y = ofs_reg[1] ? s_neg : s_pos;
    assign corner_z = ofs_reg[0] ? s_neg : s_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result.ready && state_reg != S_WRITE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        beyond_reg <= 1'b0;
                        x_reg      <= '0;
                        y_reg      <= '0;
                        z_reg      <= '0;
                        state_reg  <= shell_start ? S_FIND : S_WRITE;
                    end
                end
                S_FIND:
                begin
                    if (shell_done)
                    begin
                        beyond_reg <= shell.beyond;
                        r_reg      <= shell.r;
                        n_reg      <= shell.n;
                        nsq_reg    <= shell.nsq;
                        ofs_reg    <= shell.ofs;
                        cnt_reg    <= GRP_FIRST;
                        state_reg  <= shell.beyond ? S_WRITE : S_FACE;
                    end
                end
                S_FACE:
                begin
                    if (cnt_reg == GRP_DONE)
                    begin
                        cnt_reg   <= GRP_FIRST;
                        state_reg <= S_EDGE;
                    end
                    else if (ge)
                    begin
                        ofs_reg <= diff[OFS_W-1:0];
                        cnt_reg <= cnt_reg + 2'd1;
                    end
                    else
                    begin
                        // halve to drop the sign bit, then divide by n
                        sgn_reg   <= ofs_reg[0];
                        ofs_reg   <= ofs_reg >> 1;
                        q_reg     <= '0;
                        bit_reg   <= BIT_TOP;
                        state_reg <= S_DIV;
                    end
                end
                S_EDGE:
                begin
                    if (cnt_reg == GRP_DONE)
                    begin
                        x_reg     <= corner_x;
                        y_reg     <= corner_y;
                        z_reg     <= corner_z;
                        state_reg <= S_WRITE;
                    end
                    else if (ge)
                    begin
                        ofs_reg <= diff[OFS_W-1:0];
                        cnt_reg <= cnt_reg + 2'd1;
                    end
                    else
                    begin
                        case (cnt_reg)
                            GRP_FIRST:
                            begin
                                x_reg <= edge_va;
                                y_reg <= edge_s1;
                                z_reg <= edge_s2;
                            end
                            GRP_SECOND:
                            begin
                                z_reg <= edge_va;
                                x_reg <= edge_s1;
                                y_reg <= edge_s2;
                            end
                            default:
                            begin
                                y_reg <= edge_va;
                                x_reg <= edge_s1;
                                z_reg <= edge_s2;
                            end
                        endcase
                        state_reg <= S_WRITE;
                    end
                end
                S_DIV:
                begin
                    q_reg   <= q_new;
                    ofs_reg <= rem_new;
                    bit_reg <= bit_reg - BIT_W'(1);
                    if (bit_reg == '0)
                    begin
                        case (cnt_reg)
                            GRP_FIRST:
                            begin
                                x_reg <= face_va;
                                z_reg <= face_vb;
                                y_reg <= face_s;
                            end
                            GRP_SECOND:
                            begin
                                x_reg <= face_va;
                                y_reg <= face_vb;
                                z_reg <= face_s;
                            end
                            GRP_THIRD:
                            begin
                                z_reg <= face_va;
                                y_reg <= face_vb;
                                x_reg <= face_s;
                            end
                            default:
                            begin
                                x_reg <= '0;
                                y_reg <= '0;
                                z_reg <= '0;
                            end
                        endcase
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_x_reg      <= x_reg;
                        out_y_reg      <= y_reg;
                        out_z_reg      <= z_reg;
                        out_beyond_reg <= beyond_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.pos_x        = out_x_reg;
    assign result.pos_y        = out_y_reg;
    assign result.pos_z        = out_z_reg;
    assign result.beyond_range = out_beyond_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !query.ready)
        else $error("query taken while a lookup is in flight");

    a_find_done_in_find: assert property (@(posedge clk) disable iff (!rst_n)
        shell_done |-> state_reg == S_FIND)
        else $error("shell search finished outside the search phase");

    a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.beyond_range) |->
            (result.pos_x == '0 && result.pos_y == '0 && result.pos_z == '0))
        else $error("out-of-range item carries nonzero coordinates");

    a_write_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished item not moved to the output register");

endmodule

// ===== src/csip_shell_find.sv =====
`timescale 1ns / 1ps

module csip_shell_find #(
    parameter int MAX_SHELL = csip_pkg::DEFAULT_MAX_SHELL
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [csip_pkg::IDX_W-1:0]  idx,
    output logic                        done,
    output csip_pkg::csip_shell_t       shell
);
    import csip_pkg::*;

    localparam int SHELL_W = (MAX_SHELL > 1) ? $clog2(MAX_SHELL + 1) : 1;
    localparam logic [SHELL_W-1:0] LAST_K = SHELL_W'(MAX_SHELL);

    typedef enum logic {F_IDLE, F_RUN} find_state_t;

    find_state_t          state_reg;
    logic                 done_reg;
    csip_shell_t          shell_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SHELL_W-1:0]   k_reg;
    logic [COORD_W-1:0]   r_reg;
    logic [N_W-1:0]       n_reg;
    logic [CUBE_W-1:0]    lo_cube_reg;
    logic [CUBE_W-1:0]    hi_cube_reg;
    logic [CUBE_W-1:0]    d1_reg;
    logic [CUBE_W-1:0]    d2_reg;
    logic [SQ_W-1:0]      lo_sq_reg;
    logic [SQ_W-1:0]      hi_sq_reg;
    logic [SQ_W-1:0]      sq_step_reg;

    logic                 inside_hi;
    logic [CUBE_W-1:0]    ofs_full;

    assign inside_hi = CUBE_W'(idx_reg) < hi_cube_reg;
    assign ofs_full  = CUBE_W'(idx_reg) - lo_cube_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg     <= idx;
                        k_reg       <= SHELL_W'(1);
                        r_reg       <= COORD_W'(1);
                        n_reg       <= N_W'(1);
                        lo_cube_reg <= CUBE_W'(1);
                        hi_cube_reg <= CUBE_W'(27);
                        d1_reg      <= CUBE_W'(98);
                        d2_reg      <= CUBE_W'(120);
                        lo_sq_reg   <= SQ_W'(1);
                        hi_sq_reg   <= SQ_W'(9);
                        sq_step_reg <= SQ_W'(16);
                        state_reg   <= F_RUN;
                    end
                end
                F_RUN:
                begin
                    if (inside_hi)
                    begin
                        shell_reg.beyond <= 1'b0;
                        shell_reg.r      <= r_reg;
                        shell_reg.n      <= n_reg;
                        shell_reg.nsq    <= lo_sq_reg;
                        shell_reg.ofs    <= ofs_full[OFS_W-1:0];
                        done_reg         <= 1'b1;
                        state_reg        <= F_IDLE;
                    end
                    else if (k_reg == LAST_K)
                    begin
                        shell_reg.beyond <= 1'b1;
                        shell_reg.r      <= '0;
                        shell_reg.n      <= '0;
                        shell_reg.nsq    <= '0;
                        shell_reg.ofs    <= '0;
                        done_reg         <= 1'b1;
                        state_reg        <= F_IDLE;
                    end
                    else
                    begin
                        // advance one shell by forward differences
                        lo_cube_reg <= hi_cube_reg;
                        hi_cube_reg <= hi_cube_reg + d1_reg;
                        d1_reg      <= d1_reg + d2_reg;
                        d2_reg      <= d2_reg + CUBE_W'(48);
                        lo_sq_reg   <= hi_sq_reg;
                        hi_sq_reg   <= hi_sq_reg + sq_step_reg;
                        sq_step_reg <= sq_step_reg + SQ_W'(8);
                        k_reg       <= k_reg + SHELL_W'(1);
                        r_reg       <= r_reg + COORD_W'(1);
                        n_reg       <= n_reg + N_W'(2);
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign shell = shell_reg;

endmodule

// ===== tb/sv/cube_shell_index_to_position_top_tb.sv =====
`timescale 1ns / 1ps

module cube_shell_index_to_position_top_tb;
    import csip_pkg::*;

    localparam int MAX_SHELL   = DEFAULT_MAX_SHELL;
    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 12;
    localparam int RANDOM_LEN  = 1326;
    localparam int HOLD_LEN    = 2000;
    localparam int DRAIN_LEN   = MAX_SHELL + 40;
    localparam int CYCLE_LIMIT = 2000000;
    localparam longint LAST_INDEX = (longint'(1) << IDX_W) - 1;

    typedef struct {
        logic [IDX_W-1:0]          index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      beyond;
        int                        shell;
    } position_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic             drv_valid = 1'b0;
    logic [IDX_W-1:0] drv_index = '0;
    logic             rx_ready  = 1'b0;

    csip_in_if  query_ch ();
    csip_out_if result_ch ();

    assign query_ch.valid          = drv_valid;
    assign query_ch.position_index = drv_index;
    assign result_ch.ready         = rx_ready;

    cube_shell_index_to_position_top #(
        .MAX_SHELL (MAX_SHELL)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    logic [IDX_W-1:0] pending_indices[$];
    position_t        expected_positions[$];
    position_t        oldest;

    int     queued_total     = 0;
    int     queries_accepted = 0;
    int     results_checked  = 0;
    int     beyond_seen      = 0;
    int     deepest_shell    = 0;
    int     mismatch_count   = 0;
    int     hold_left        = 0;
    logic   hold_done        = 1'b0;
    longint cycle_count      = 0;

    always #CLK_HALF clk = ~clk;

    function automatic position_t locate_position(logic [IDX_W-1:0] index);
        position_t p;
        longint idx, r, n, o, face_len, edge_len, lo, grp, rem, va, vb, s1, s2, x, y, z;
        idx = longint'(index);
        r = 0;
        x = 0;
        y = 0;
        z = 0;
        p.index  = index;
        p.beyond = 1'b0;
        if (idx != 0) begin
            for (longint k = 1; k <= MAX_SHELL; k++) begin
                if (r == 0 && idx < (2 * k + 1) * (2 * k + 1) * (2 * k + 1))
                    r = k;
            end
            if (r == 0) begin
                p.beyond = 1'b1;
            end
            else begin
                n        = 2 * r - 1;
                o        = idx - n * n * n;
                face_len = 2 * n * n;
                edge_len = 4 * n;
                lo       = r - 1;
                if (o < 3 * face_len) begin
                    grp = o / face_len;
                    rem = o % face_len;
                    va  = rem / (2 * n) - lo;
                    vb  = (rem % (2 * n)) / 2 - lo;
                    s1  = rem[0] ? -r : r;
                    if (grp == 0) begin
                        x = va; z = vb; y = s1;
                    end
                    else if (grp == 1) begin
                        x = va; y = vb; z = s1;
                    end
                    else begin
                        z = va; y = vb; x = s1;
                    end
                end
                else if (o - 3 * face_len < 3 * edge_len) begin
                    o   = o - 3 * face_len;
                    grp = o / edge_len;
                    rem = o % edge_len;
                    va  = rem / 4 - lo;
                    s1  = rem[1] ? -r : r;
                    s2  = rem[0] ? -r : r;
                    if (grp == 0) begin
                        x = va; y = s1; z = s2;
                    end
                    else if (grp == 1) begin
                        z = va; x = s1; y = s2;
                    end
                    else begin
                        y = va; x = s1; z = s2;
                    end
                end
                else begin
                    o = o - 3 * face_len - 3 * edge_len;
                    x = o[2] ? -r : r;
                    y = o[1] ? -r : r;
                    z = o[0] ? -r : r;
                end
            end
        end
        p.x     = x[COORD_W-1:0];
        p.y     = y[COORD_W-1:0];
        p.z     = z[COORD_W-1:0];
        p.shell = int'(r);
        return p;
    endfunction

    function automatic longint shell_base(int r);
        longint n;
        n = 2 * r - 1;
        return n * n * n;
    endfunction

    task automatic add_query(longint idx);
        pending_indices.push_back(idx[IDX_W-1:0]);
        queued_total++;
    endtask

    task automatic add_shell_query(int r, longint o);
        add_query(shell_base(r) + o);
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // driver: hold the item until accepted, then advance or idle
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
            drv_index <= '0;
        end
        else if (!drv_valid || query_ch.ready) begin
            if (pending_indices.size() > 0 &&
                ((queries_accepted >= 300 && queries_accepted < 500) ||
                 $urandom_range(99) >= 25)) begin
                drv_valid <= 1'b1;
                drv_index <= pending_indices.pop_front();
            end
            else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off, one stall-free stretch
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rx_ready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0) begin
            rx_ready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_checked >= 150) begin
            rx_ready  <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else begin
            rx_ready <= (results_checked >= 700 && results_checked < 900) ||
                        ($urandom_range(99) >= 25);
        end
    end

    // monitor: predict on query accept, check on result accept
    always @(posedge clk) begin
        if (rst_n) begin
            if (query_ch.valid && query_ch.ready) begin
                expected_positions.push_back(locate_position(query_ch.position_index));
                queries_accepted++;
            end
            if (result_ch.valid && result_ch.ready) begin
                if (expected_positions.size() == 0) begin
                    report_mismatch("result with no query outstanding");
                end
                else begin
                    oldest = expected_positions.pop_front();
                    if (result_ch.pos_x !== oldest.x)
                        report_mismatch($sformatf("index %0d pos_x %0d, want %0d",
                                        oldest.index, result_ch.pos_x, oldest.x));
                    if (result_ch.pos_y !== oldest.y)
                        report_mismatch($sformatf("index %0d pos_y %0d, want %0d",
                                        oldest.index, result_ch.pos_y, oldest.y));
                    if (result_ch.pos_z !== oldest.z)
                        report_mismatch($sformatf("index %0d pos_z %0d, want %0d",
                                        oldest.index, result_ch.pos_z, oldest.z));
                    if (result_ch.beyond_range !== oldest.beyond)
                        report_mismatch($sformatf("index %0d beyond_range %b, want %b",
                                        oldest.index, result_ch.beyond_range,
                                        oldest.beyond));
                    results_checked++;
                    if (oldest.beyond)
                        beyond_seen++;
                    if (oldest.shell > deepest_shell)
                        deepest_shell = oldest.shell;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d items checked",
                     cycle_count, results_checked, queued_total);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int     r, n, pick;
        longint o;

        // origin, shell 1 faces, edges and corners
        add_query(0);
        add_shell_query(1, 0);
        add_shell_query(1, 1);
        add_shell_query(1, 3);
        add_shell_query(1, 5);
        add_shell_query(1, 6);
        add_shell_query(1, 10);
        add_shell_query(1, 17);
        add_shell_query(1, 18);
        add_shell_query(1, 25);
        // shell 2 boundaries
        add_shell_query(2, 0);
        add_shell_query(2, 53);
        add_shell_query(2, 54);
        add_shell_query(2, 89);
        add_shell_query(2, 90);
        add_shell_query(2, 97);
        // largest shell and past it
        add_shell_query(MAX_SHELL, 0);
        add_shell_query(MAX_SHELL, 6 * (2 * MAX_SHELL - 1) * (2 * MAX_SHELL - 1) - 1);
        add_shell_query(MAX_SHELL, 6 * (2 * MAX_SHELL - 1) * (2 * MAX_SHELL - 1));
        add_shell_query(MAX_SHELL, 6 * (2 * MAX_SHELL - 1) * (2 * MAX_SHELL - 1)
                                   + 12 * (2 * MAX_SHELL - 1));
        add_query(shell_base(MAX_SHELL + 1) - 1);
        add_query(shell_base(MAX_SHELL + 1));
        add_query(LAST_INDEX);
        add_query(longint'(1) << (IDX_W - 1));

        for (int i = 0; i < RANDOM_LEN; i++) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                add_query($urandom_range(int'(LAST_INDEX), int'(shell_base(MAX_SHELL + 1))));
            end
            else if (pick < 15) begin
                add_query(longint'($urandom()) & LAST_INDEX);
            end
            else begin
                r = $urandom_range(1) ? $urandom_range(12, 1) : $urandom_range(MAX_SHELL, 1);
                n = 2 * r - 1;
                pick = $urandom_range(9);
                if (pick < 5)
                    o = $urandom_range(6 * n * n - 1);
                else if (pick < 8)
                    o = 6 * n * n + $urandom_range(12 * n - 1);
                else
                    o = 6 * n * n + 12 * n + $urandom_range(7);
                add_shell_query(r, o);
            end
        end

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;

        while (queries_accepted < queued_total)
            @(posedge clk);
        while (expected_positions.size() > 0)
            @(posedge clk);
        repeat (DRAIN_LEN) @(posedge clk);

        $display("Checked %0d lookups reaching shell %0d, %0d past the largest shell;",
                 results_checked, deepest_shell, beyond_seen);
        $display("result side held off for %0d cycles once, with random gaps on both sides.",
                 HOLD_LEN);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
